// ===== hw/rtl/csha_pkg.sv =====
package csha_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SLOW_ALPHA  = 2'd0,
        CFG_FAST_ALPHA  = 2'd1,
        CFG_FAST_FRAMES = 2'd2,
        CFG_EPS_FLOOR   = 2'd3
    } t_cfg_idx;

    localparam int unsigned BIN_W   = 14;
    localparam int unsigned SPEC_W  = 24;
    localparam int unsigned AUTO_W  = 48;
    localparam int unsigned CROSS_W = 49;
    localparam int unsigned H_W     = 32;
    localparam int unsigned COH_W   = 17;

    localparam logic [15:0] SLOW_ALPHA_RST  = 16'd61911;
    localparam logic [15:0] FAST_ALPHA_RST  = 16'd49323;
    localparam logic [7:0]  FAST_FRAMES_RST = 8'd30;
    localparam logic [31:0] EPS_FLOOR_RST   = 32'd1;

    // Cross terms are stored offset by this bias so they stay non-negative.
    localparam logic [CROSS_W-1:0] XBIAS = 49'h0_8000_0000_0000;

    // Coherence of 1.0 in Q0.16.
    localparam logic [COH_W-1:0] COH_ONE = 17'h1_0000;

    // One word of the per-bin store.
    typedef struct packed {
        logic [AUTO_W-1:0]  auto_ref;
        logic [AUTO_W-1:0]  auto_meas;
        logic [CROSS_W-1:0] cross_real;
        logic [CROSS_W-1:0] cross_imag;
    } t_bin_state;

    localparam t_bin_state BIN_STATE_CLR = '{
        auto_ref:   '0,
        auto_meas:  '0,
        cross_real: XBIAS,
        cross_imag: XBIAS
    };

endpackage

// ===== hw/rtl/cross_spectrum_h1_averager.sv =====
// H1 transfer function estimator with magnitude-squared coherence. Each item is one FFT bin:
// reference spectrum X and measurement spectrum Y with signed 24-bit parts. Per bin the block
// keeps exponential averages of |X|^2, |Y|^2 and Y*conj(X) in an on-chip store of
// FFT_SIZE/2+1 words, using fast_alpha for the first fast_frames frames and slow_alpha after
// that, and returns H1 = Gxy/(Gxx+eps) in saturated Q16.16 together with coherence
// |Gxy|^2/(Gxx*Gyy+eps) in Q0.16, clamped to 1.0. Bins above FFT_SIZE/2 leave the store alone
// and return zeros. The block accepts one item per clock while o_stall is low; the pipeline
// depth is set by the two bit-per-stage dividers (32 quotient bits for H1, run alongside 16
// bits for coherence). Besides back-pressure from i_stall and the clearing sweep, the full
// rate is broken by a bin that is still inside the four-stage read-modify-write window of the
// store: an item whose bin matches an item in the first four stages is held off with o_stall
// until that update has been written back, so bins that repeat closer than five items apart
// slow the input. After reset the store is cleared by a sweep over all FFT_SIZE/2+1 words
// (8193 at the default size) during which o_stall stays high; configuration writes are taken
// at any time, one per cycle, and must only be issued while no item is in flight.
module cross_spectrum_h1_averager
    import csha_pkg::*;
#(
    parameter int unsigned FFT_SIZE = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [BIN_W-1:0]         i_bin,
    input  logic signed [SPEC_W-1:0] i_x_re,
    input  logic signed [SPEC_W-1:0] i_x_im,
    input  logic signed [SPEC_W-1:0] i_y_re,
    input  logic signed [SPEC_W-1:0] i_y_im,
    input  logic                     i_frame_end,

    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [BIN_W-1:0]         o_out_bin,
    output logic signed [H_W-1:0]    o_h_re,
    output logic signed [H_W-1:0]    o_h_im,
    output logic [COH_W-1:0]         o_coherence,
    output logic                     o_fast_used,
    output logic                     o_out_frame_end,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [31:0]              i_cfg_data
);

    localparam int unsigned NBINS   = FFT_SIZE / 2 + 1;
    localparam int unsigned AW      = $clog2(NBINS);
    localparam int unsigned CMPW    = (AW > BIN_W) ? AW : BIN_W;
    localparam int unsigned DSTEPS  = 32;   // H1 quotient bits
    localparam int unsigned COHBITS = 16;   // coherence quotient bits
    localparam int unsigned NS      = 8 + DSTEPS + 2;
    localparam int unsigned DW      = 49;   // H1 divisor width
    localparam int unsigned CW      = 96;   // coherence operand width

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_slow_alpha;
    logic [15:0] r_fast_alpha;
    logic [7:0]  r_fast_frames;
    logic [31:0] r_eps_floor;
    logic [31:0] eps_eff;

    assign o_cfg_ready = 1'b1;
    assign eps_eff     = (r_eps_floor == '0) ? 32'd1 : r_eps_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_alpha  <= SLOW_ALPHA_RST;
            r_fast_alpha  <= FAST_ALPHA_RST;
            r_fast_frames <= FAST_FRAMES_RST;
            r_eps_floor   <= EPS_FLOOR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SLOW_ALPHA:  r_slow_alpha  <= i_cfg_data[15:0];
                CFG_FAST_ALPHA:  r_fast_alpha  <= i_cfg_data[15:0];
                CFG_FAST_FRAMES: r_fast_frames <= i_cfg_data[7:0];
                CFG_EPS_FLOOR:   r_eps_floor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a valid bit per stage, a stage loads when it is
    // empty or its item moves on, so bubbles close up under a stall.
    // ------------------------------------------------------------------
    logic [NS:1]   r_v;
    logic [NS+1:1] rdy;
    logic [NS:0]   vchain;
    logic          v_in;
    logic          accept;
    logic          hazard;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic [7:0]    r_frames;

    assign rdy[NS+1] = !i_stall;
    for (genvar k = 1; k <= NS; k++) begin : g_rdy
        assign rdy[k] = !r_v[k] || rdy[k+1];
    end

    assign vchain = {r_v, v_in};
    assign v_in   = i_valid && !hazard && !r_clr_busy;
    assign accept = v_in && rdy[1];
    assign o_stall = r_clr_busy || hazard || !rdy[1];
    assign o_valid = r_v[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= vchain[k-1];
                end
            end
        end
    end

    // Frame counter: saturates, never returns to the fast phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= '0;
        end else if (accept && i_frame_end && (r_frames != 8'hFF)) begin
            r_frames <= r_frames + 8'd1;
        end
    end

    // Clearing sweep of the per-bin store after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(NBINS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage registers of the front end
    // ------------------------------------------------------------------
    logic [BIN_W-1:0]         r_s1_bin, r_s2_bin, r_s3_bin, r_s4_bin;
    logic [BIN_W-1:0]         r_s5_bin, r_s6_bin, r_s7_bin, r_s8_bin;
    logic [8:1]               r_fe, r_fast, r_inr;
    logic signed [SPEC_W-1:0] r_s1_xr, r_s1_xi, r_s1_yr, r_s1_yi;
    t_bin_state               r_s1_old, r_s2_old, r_s3_old;
    logic [15:0]              r_s2_a, r_s3_a;
    logic signed [47:0]       r_s2_xrxr, r_s2_xixi, r_s2_yryr, r_s2_yiyi;
    logic signed [47:0]       r_s2_yrxr, r_s2_yixi, r_s2_yixr, r_s2_yrxi;
    t_bin_state               r_s3_inst;
    logic [64:0]              r_s4_pa [4];
    logic [65:0]              r_s4_pb [4];
    logic [CROSS_W-1:0]       r_s5_g [4];
    logic [47:0]              r_s6_mr, r_s6_mi, r_s6_gxx, r_s6_gyy;
    logic                     r_s6_nr, r_s6_ni, r_s7_nr, r_s7_ni, r_s8_nr, r_s8_ni;
    logic [DW-1:0]            r_s6_den, r_s7_den, r_s8_den;
    logic [47:0]              r_s7_rhh, r_s7_rhl, r_s7_rll, r_s7_ihh, r_s7_ihl, r_s7_ill;
    logic [47:0]              r_s7_ghh, r_s7_ghl, r_s7_glh, r_s7_gll;
    logic [64:0]              r_s7_nre, r_s7_nim, r_s8_nre, r_s8_nim;
    logic [CW-1:0]            r_s8_sqr, r_s8_sqi, r_s8_gg;

    // Hold off an item whose bin has not been written back yet.
    assign hazard = (r_v[1] && r_s1_bin == i_bin) || (r_v[2] && r_s2_bin == i_bin) ||
                    (r_v[3] && r_s3_bin == i_bin) || (r_v[4] && r_s4_bin == i_bin);

    logic [CMPW-1:0] in_bin_ext, s4_bin_ext;
    logic            in_range;
    assign in_bin_ext = CMPW'(i_bin);
    assign s4_bin_ext = CMPW'(r_s4_bin);
    assign in_range   = in_bin_ext < CMPW'(NBINS);

    // ------------------------------------------------------------------
    // Per-bin store: read as an item enters, written as it leaves stage 4
    // ------------------------------------------------------------------
    t_bin_state   mem [NBINS];
    t_bin_state   s4_new;
    logic         mem_wr;
    logic [66:0]  s4_sum [4];

    for (genvar i = 0; i < 4; i++) begin : g_blend_sum
        assign s4_sum[i] = 67'(r_s4_pa[i]) + 67'(r_s4_pb[i]) + 67'd32768;
    end
    assign s4_new.auto_ref   = s4_sum[0][63:16];
    assign s4_new.auto_meas  = s4_sum[1][63:16];
    assign s4_new.cross_real = s4_sum[2][64:16];
    assign s4_new.cross_imag = s4_sum[3][64:16];
    assign mem_wr = r_v[4] && rdy[5] && r_inr[4];

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= BIN_STATE_CLR;
        end else if (mem_wr) begin
            mem[s4_bin_ext[AW-1:0]] <= s4_new;
        end
        if (rdy[1]) begin
            r_s1_old <= mem[in_bin_ext[AW-1:0]];
        end
    end

    // Stage 1: capture the item.
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1_bin <= i_bin;
            r_fe[1]  <= i_frame_end;
            r_fast[1] <= r_frames < r_fast_frames;
            r_inr[1] <= in_range;
            r_s1_xr  <= i_x_re;
            r_s1_xi  <= i_x_im;
            r_s1_yr  <= i_y_re;
            r_s1_yi  <= i_y_im;
        end
    end

    // Stage 2: instantaneous products.
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_s2_bin  <= r_s1_bin;
            r_fe[2]   <= r_fe[1];
            r_fast[2] <= r_fast[1];
            r_inr[2]  <= r_inr[1];
            r_s2_old  <= r_s1_old;
            r_s2_a    <= r_fast[1] ? r_fast_alpha : r_slow_alpha;
            r_s2_xrxr <= r_s1_xr * r_s1_xr;
            r_s2_xixi <= r_s1_xi * r_s1_xi;
            r_s2_yryr <= r_s1_yr * r_s1_yr;
            r_s2_yiyi <= r_s1_yi * r_s1_yi;
            r_s2_yrxr <= r_s1_yr * r_s1_xr;
            r_s2_yixi <= r_s1_yi * r_s1_xi;
            r_s2_yixr <= r_s1_yi * r_s1_xr;
            r_s2_yrxi <= r_s1_yr * r_s1_xi;
        end
    end

    // Stage 3: auto and cross powers; cross terms carry the bias.
    logic [49:0] s2_cre, s2_cim;
    assign s2_cre = {{2{r_s2_yrxr[47]}}, r_s2_yrxr} + {{2{r_s2_yixi[47]}}, r_s2_yixi} +
                    {1'b0, XBIAS};
    assign s2_cim = {{2{r_s2_yixr[47]}}, r_s2_yixr} - {{2{r_s2_yrxi[47]}}, r_s2_yrxi} +
                    {1'b0, XBIAS};

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s3_bin  <= r_s2_bin;
            r_fe[3]   <= r_fe[2];
            r_fast[3] <= r_fast[2];
            r_inr[3]  <= r_inr[2];
            r_s3_old  <= r_s2_old;
            r_s3_a    <= r_s2_a;
            r_s3_inst.auto_ref   <= r_s2_xrxr + r_s2_xixi;
            r_s3_inst.auto_meas  <= r_s2_yryr + r_s2_yiyi;
            r_s3_inst.cross_real <= s2_cre[48:0];
            r_s3_inst.cross_imag <= s2_cim[48:0];
        end
    end

    // Stage 4: weighted old value and weighted new value.
    logic [16:0]        s3_wb;
    logic [CROSS_W-1:0] s3_old_w [4];
    logic [CROSS_W-1:0] s3_inst_w [4];
    assign s3_wb = 17'h1_0000 - {1'b0, r_s3_a};
    assign s3_old_w[0]  = {1'b0, r_s3_old.auto_ref};
    assign s3_old_w[1]  = {1'b0, r_s3_old.auto_meas};
    assign s3_old_w[2]  = r_s3_old.cross_real;
    assign s3_old_w[3]  = r_s3_old.cross_imag;
    assign s3_inst_w[0] = {1'b0, r_s3_inst.auto_ref};
    assign s3_inst_w[1] = {1'b0, r_s3_inst.auto_meas};
    assign s3_inst_w[2] = r_s3_inst.cross_real;
    assign s3_inst_w[3] = r_s3_inst.cross_imag;

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_s4_bin  <= r_s3_bin;
            r_fe[4]   <= r_fe[3];
            r_fast[4] <= r_fast[3];
            r_inr[4]  <= r_inr[3];
            for (int i = 0; i < 4; i++) begin
                r_s4_pa[i] <= r_s3_a * s3_old_w[i];
                r_s4_pb[i] <= s3_wb * s3_inst_w[i];
            end
        end
    end

    // Stage 5: updated averages (also written back to the store).
    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_s5_bin  <= r_s4_bin;
            r_fe[5]   <= r_fe[4];
            r_fast[5] <= r_fast[4];
            r_inr[5]  <= r_inr[4];
            r_s5_g[0] <= {1'b0, s4_new.auto_ref};
            r_s5_g[1] <= {1'b0, s4_new.auto_meas};
            r_s5_g[2] <= s4_new.cross_real;
            r_s5_g[3] <= s4_new.cross_imag;
        end
    end

    // Stage 6: sign and magnitude of Gxy, H1 denominator.
    logic        s5_nr, s5_ni;
    logic [48:0] s5_mr, s5_mi;
    assign s5_nr = r_s5_g[2] < XBIAS;
    assign s5_ni = r_s5_g[3] < XBIAS;
    assign s5_mr = s5_nr ? (XBIAS - r_s5_g[2]) : (r_s5_g[2] - XBIAS);
    assign s5_mi = s5_ni ? (XBIAS - r_s5_g[3]) : (r_s5_g[3] - XBIAS);

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_s6_bin  <= r_s5_bin;
            r_fe[6]   <= r_fe[5];
            r_fast[6] <= r_fast[5];
            r_inr[6]  <= r_inr[5];
            r_s6_nr   <= s5_nr;
            r_s6_ni   <= s5_ni;
            r_s6_mr   <= s5_mr[47:0];
            r_s6_mi   <= s5_mi[47:0];
            r_s6_gxx  <= r_s5_g[0][47:0];
            r_s6_gyy  <= r_s5_g[1][47:0];
            r_s6_den  <= r_s5_g[0] + {17'd0, eps_eff};
        end
    end

    // Stage 7: 24x24 partial products, rounded H1 dividends.
    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r_s7_bin  <= r_s6_bin;
            r_fe[7]   <= r_fe[6];
            r_fast[7] <= r_fast[6];
            r_inr[7]  <= r_inr[6];
            r_s7_nr   <= r_s6_nr;
            r_s7_ni   <= r_s6_ni;
            r_s7_den  <= r_s6_den;
            r_s7_rhh  <= r_s6_mr[47:24] * r_s6_mr[47:24];
            r_s7_rhl  <= r_s6_mr[47:24] * r_s6_mr[23:0];
            r_s7_rll  <= r_s6_mr[23:0] * r_s6_mr[23:0];
            r_s7_ihh  <= r_s6_mi[47:24] * r_s6_mi[47:24];
            r_s7_ihl  <= r_s6_mi[47:24] * r_s6_mi[23:0];
            r_s7_ill  <= r_s6_mi[23:0] * r_s6_mi[23:0];
            r_s7_ghh  <= r_s6_gxx[47:24] * r_s6_gyy[47:24];
            r_s7_ghl  <= r_s6_gxx[47:24] * r_s6_gyy[23:0];
            r_s7_glh  <= r_s6_gxx[23:0] * r_s6_gyy[47:24];
            r_s7_gll  <= r_s6_gxx[23:0] * r_s6_gyy[23:0];
            r_s7_nre  <= {1'b0, r_s6_mr, 16'd0} + 65'(r_s6_den >> 1);
            r_s7_nim  <= {1'b0, r_s6_mi, 16'd0} + 65'(r_s6_den >> 1);
        end
    end

    // Stage 8: full-width squares and Gxx*Gyy.
    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r_s8_bin  <= r_s7_bin;
            r_fe[8]   <= r_fe[7];
            r_fast[8] <= r_fast[7];
            r_inr[8]  <= r_inr[7];
            r_s8_nr   <= r_s7_nr;
            r_s8_ni   <= r_s7_ni;
            r_s8_den  <= r_s7_den;
            r_s8_nre  <= r_s7_nre;
            r_s8_nim  <= r_s7_nim;
            r_s8_sqr  <= {r_s7_rhh, 48'd0} + {23'd0, r_s7_rhl, 25'd0} + {48'd0, r_s7_rll};
            r_s8_sqi  <= {r_s7_ihh, 48'd0} + {23'd0, r_s7_ihl, 25'd0} + {48'd0, r_s7_ill};
            r_s8_gg   <= {r_s7_ghh, 48'd0} + {24'd0, r_s7_ghl, 24'd0} +
                         {24'd0, r_s7_glh, 24'd0} + {48'd0, r_s7_gll};
        end
    end

    // ------------------------------------------------------------------
    // Divider pipeline: one quotient bit per stage for both H1 parts,
    // one coherence bit per stage for the first sixteen stages.
    // ------------------------------------------------------------------
    logic [BIN_W-1:0] r_d_bin  [DSTEPS+1];
    logic             r_d_fe   [DSTEPS+1];
    logic             r_d_fast [DSTEPS+1];
    logic             r_d_inr  [DSTEPS+1];
    logic             r_d_nr   [DSTEPS+1];
    logic             r_d_ni   [DSTEPS+1];
    logic             r_d_ovr  [DSTEPS+1];
    logic             r_d_ovi  [DSTEPS+1];
    logic [DW-1:0]    r_d_den  [DSTEPS+1];
    logic [DW-1:0]    r_d_rre  [DSTEPS+1];
    logic [DW-1:0]    r_d_rim  [DSTEPS+1];
    logic [31:0]      r_d_nlr  [DSTEPS+1];
    logic [31:0]      r_d_nli  [DSTEPS+1];
    logic [31:0]      r_d_qre  [DSTEPS+1];
    logic [31:0]      r_d_qim  [DSTEPS+1];
    logic [CW-1:0]    r_d_dd   [DSTEPS+1];
    logic [CW-1:0]    r_d_crem [DSTEPS+1];
    logic [15:0]      r_d_cq   [DSTEPS+1];
    logic             r_d_cful [DSTEPS+1];

    always_ff @(posedge i_clk) begin
        if (rdy[9]) begin
            r_d_bin[0]  <= r_s8_bin;
            r_d_fe[0]   <= r_fe[8];
            r_d_fast[0] <= r_fast[8];
            r_d_inr[0]  <= r_inr[8];
            r_d_nr[0]   <= r_s8_nr;
            r_d_ni[0]   <= r_s8_ni;
            r_d_ovr[0]  <= {16'd0, r_s8_nre[64:32]} >= r_s8_den;
            r_d_ovi[0]  <= {16'd0, r_s8_nim[64:32]} >= r_s8_den;
            r_d_den[0]  <= r_s8_den;
            r_d_rre[0]  <= {16'd0, r_s8_nre[64:32]};
            r_d_rim[0]  <= {16'd0, r_s8_nim[64:32]};
            r_d_nlr[0]  <= r_s8_nre[31:0];
            r_d_nli[0]  <= r_s8_nim[31:0];
            r_d_qre[0]  <= '0;
            r_d_qim[0]  <= '0;
            r_d_dd[0]   <= r_s8_gg + {64'd0, eps_eff};
            r_d_crem[0] <= r_s8_sqr + r_s8_sqi;
            r_d_cq[0]   <= '0;
            r_d_cful[0] <= 1'b0;
        end
    end

    for (genvar j = 0; j < DSTEPS; j++) begin : g_div
        logic [DW:0] re_sh, im_sh;
        logic        re_ge, im_ge;

        assign re_sh = {r_d_rre[j], r_d_nlr[j][31]};
        assign im_sh = {r_d_rim[j], r_d_nli[j][31]};
        assign re_ge = re_sh >= {1'b0, r_d_den[j]};
        assign im_ge = im_sh >= {1'b0, r_d_den[j]};

        always_ff @(posedge i_clk) begin
            if (rdy[10+j]) begin
                r_d_bin[j+1]  <= r_d_bin[j];
                r_d_fe[j+1]   <= r_d_fe[j];
                r_d_fast[j+1] <= r_d_fast[j];
                r_d_inr[j+1]  <= r_d_inr[j];
                r_d_nr[j+1]   <= r_d_nr[j];
                r_d_ni[j+1]   <= r_d_ni[j];
                r_d_ovr[j+1]  <= r_d_ovr[j];
                r_d_ovi[j+1]  <= r_d_ovi[j];
                r_d_den[j+1]  <= r_d_den[j];
                r_d_dd[j+1]   <= r_d_dd[j];
                r_d_rre[j+1]  <= re_ge ? DW'(re_sh - {1'b0, r_d_den[j]}) : re_sh[DW-1:0];
                r_d_rim[j+1]  <= im_ge ? DW'(im_sh - {1'b0, r_d_den[j]}) : im_sh[DW-1:0];
                r_d_nlr[j+1]  <= {r_d_nlr[j][30:0], 1'b0};
                r_d_nli[j+1]  <= {r_d_nli[j][30:0], 1'b0};
                r_d_qre[j+1]  <= {r_d_qre[j][30:0], re_ge};
                r_d_qim[j+1]  <= {r_d_qim[j][30:0], im_ge};
            end
        end

        if (j < COHBITS) begin : g_coh
            logic [CW:0] c_sh;
            logic        c_ge;

            assign c_sh = {r_d_crem[j], 1'b0};
            assign c_ge = c_sh >= {1'b0, r_d_dd[j]};

            always_ff @(posedge i_clk) begin
                if (rdy[10+j]) begin
                    r_d_crem[j+1] <= c_ge ? CW'(c_sh - {1'b0, r_d_dd[j]}) : c_sh[CW-1:0];
                    r_d_cq[j+1]   <= {r_d_cq[j][14:0], c_ge};
                    if (j == 0) begin
                        r_d_cful[j+1] <= r_d_crem[j] >= r_d_dd[j];
                    end else begin
                        r_d_cful[j+1] <= r_d_cful[j];
                    end
                end
            end
        end else begin : g_coh_hold
            always_ff @(posedge i_clk) begin
                if (rdy[10+j]) begin
                    r_d_crem[j+1] <= r_d_crem[j];
                    r_d_cq[j+1]   <= r_d_cq[j];
                    r_d_cful[j+1] <= r_d_cful[j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturation and sign of H1, coherence clamp.
    // ------------------------------------------------------------------
    function automatic logic [H_W-1:0] h_sat(input logic neg, input logic ovf,
                                             input logic [31:0] q);
        logic [H_W-1:0] res;
        if (neg) begin
            if (ovf || (q[31] && (q[30:0] != '0))) begin
                res = 32'h8000_0000;
            end else begin
                res = (~q) + 32'd1;
            end
        end else begin
            if (ovf || q[31]) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = q;
            end
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (rdy[NS]) begin
            o_out_bin       <= r_d_bin[DSTEPS];
            o_out_frame_end <= r_d_fe[DSTEPS];
            o_fast_used     <= r_d_fast[DSTEPS] && r_d_inr[DSTEPS];
            if (r_d_inr[DSTEPS]) begin
                o_h_re <= h_sat(r_d_nr[DSTEPS], r_d_ovr[DSTEPS], r_d_qre[DSTEPS]);
                o_h_im <= h_sat(r_d_ni[DSTEPS], r_d_ovi[DSTEPS], r_d_qim[DSTEPS]);
                o_coherence <= r_d_cful[DSTEPS] ? COH_ONE : {1'b0, r_d_cq[DSTEPS]};
            end else begin
                o_h_re      <= '0;
                o_h_im      <= '0;
                o_coherence <= '0;
            end
        end
    end

endmodule

// ===== hw/rtl/csha_checker.sv =====
module csha_checker
    import csha_pkg::*;
#(
    parameter int unsigned FFT_SIZE = 16384
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic [BIN_W-1:0]         o_out_bin,
    input logic signed [H_W-1:0]    o_h_re,
    input logic [COH_W-1:0]         o_coherence,
    input logic                     o_fast_used
);

    // No result can be shown in the cycle after reset.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_h_re) && $stable(o_out_bin))
        else $error("stalled result changed");

    a_coh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_coherence <= COH_ONE)
        else $error("coherence above one");

    // Bins outside the half spectrum never report fast averaging or a value.
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (int'(o_out_bin) > int'(FFT_SIZE / 2)) |->
            !o_fast_used && (o_coherence == '0) && (o_h_re == '0))
        else $error("out-of-range bin produced a value");

endmodule

bind cross_spectrum_h1_averager csha_checker #(.FFT_SIZE(FFT_SIZE)) u_csha_checker (.*);
